[sv/tscd_pkg.sv]
package tscd_pkg;

  // Field and register widths
  localparam int SAMPLE_W   = 16;
  localparam int MEAN_W     = 16;
  localparam int MAG_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int THR_W      = 47;
  localparam int SUM_W      = 48;
  localparam int IDX_W      = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 48;

  // Defaults for the top-level parameters
  localparam int MAX_RUN_DEF      = 65536;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // Score datapath widths
  localparam int X_W     = SAMPLE_W + 1;          // sign-extended sample
  localparam int DIFF_W  = X_W + 1;               // sample minus mean
  localparam int ERR_W   = DIFF_W + 2;            // 2*d - change_mag
  localparam int PROD_W  = ERR_W + GAIN_W + 1;    // times gain
  localparam int SCORE_W = PROD_W - 1;            // halved, floor

  // Reset values of the configuration registers
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(1280);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEAN_REF   = CFG_IDX_W'(0),
    REG_CHANGE_MAG = CFG_IDX_W'(1),
    REG_GAIN       = CFG_IDX_W'(2),
    REG_THRESHOLD  = CFG_IDX_W'(3)
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       start_req;
  } in_req_t;

  typedef struct packed {
    logic             alarm;
    logic             side;
    logic [IDX_W-1:0] detect_index;
    logic [IDX_W-1:0] change_index;
    logic             frozen;
  } out_res_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_req_t;

  // Pipeline control travelling alongside the scores
  typedef struct packed {
    logic valid;
    logic start;
  } stage_ctl_t;

endpackage

[sv/tscd_stream_if.sv]
interface tscd_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/tscd_score.sv]
module tscd_score
  import tscd_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en_i,
  input  stage_ctl_t                 ctl_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic signed [MEAN_W-1:0]   mean_i,
  input  logic [MAG_W-1:0]           mag_i,
  input  logic [GAIN_W-1:0]          gain_i,
  output stage_ctl_t                 ctl_o,
  output logic signed [SCORE_W-1:0]  score_up_o,
  output logic signed [SCORE_W-1:0]  score_dn_o
);

  stage_ctl_t                 ctl_in_r;
  stage_ctl_t                 ctl_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SCORE_W-1:0]  score_up_r;
  logic signed [SCORE_W-1:0]  score_dn_r;

  logic signed [X_W-1:0]      x;
  logic signed [DIFF_W-1:0]   d_up;
  logic signed [DIFF_W-1:0]   d_dn;
  logic signed [ERR_W-1:0]    mag_ext;
  logic signed [ERR_W-1:0]    err_up;
  logic signed [ERR_W-1:0]    err_dn;
  logic signed [GAIN_W:0]     gain_s;
  logic signed [PROD_W-1:0]   prod_up;
  logic signed [PROD_W-1:0]   prod_dn;

  // Sign-extend the sample from its low SAMPLE_WIDTH bits; a SAMPLE_WIDTH above SAMPLE_W zero-extends it
  generate
    if (SAMPLE_WIDTH <= SAMPLE_W) begin : g_sext
      assign x = {{(X_W-SAMPLE_WIDTH){sample_r[SAMPLE_WIDTH-1]}},
                  sample_r[SAMPLE_WIDTH-1:0]};
    end else begin : g_zext
      assign x = {{(X_W-SAMPLE_W){1'b0}}, sample_r};
    end
  endgenerate

  // Deviation from the mean, doubled, less the change magnitude
  always_comb begin
    d_up    = DIFF_W'(x) - DIFF_W'(mean_i);
    d_dn    = DIFF_W'(mean_i) - DIFF_W'(x);
    mag_ext = signed'({{(ERR_W-MAG_W){1'b0}}, mag_i});
    err_up  = (ERR_W'(d_up) <<< 1) - mag_ext;
    err_dn  = (ERR_W'(d_dn) <<< 1) - mag_ext;
    gain_s  = signed'({1'b0, gain_i});
    prod_up = PROD_W'(err_up) * PROD_W'(gain_s);
    prod_dn = PROD_W'(err_dn) * PROD_W'(gain_s);
  end

  // Input register, then the halved products (dropping the LSB rounds down)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_in_r <= '0;
      ctl_r    <= '0;
    end else if (en_i) begin
      ctl_in_r <= ctl_i;
      ctl_r    <= ctl_in_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      sample_r   <= sample_i;
      score_up_r <= prod_up[PROD_W-1:1];
      score_dn_r <= prod_dn[PROD_W-1:1];
    end
  end

  assign ctl_o      = ctl_r;
  assign score_up_o = score_up_r;
  assign score_dn_o = score_dn_r;

endmodule

[sv/two_sided_cusum_detector.sv]
// Two-sided CUSUM change detector.
// in_ch carries one request per sample (sample, start_req); out_ch returns
// exactly one result per request, in order (alarm, side, detect_index,
// change_index, frozen). cfg_ch writes mean_ref, change_mag, gain and
// threshold by index; it is always ready and must only be used while no
// request is in flight. Writes to unknown indexes are dropped.
// Pipeline: an accepted request passes three registers (input, score,
// result) before its result becomes valid.
// Throughput: one request per cycle unless the receiver stalls; the two score
// multipliers sit in their own stage and the sum/minimum/threshold update is combinational.
// The three stages advance together whenever the result register is empty
// or being taken, so a stalled receiver holds the whole pipeline and
// in_ch.ready falls in the same cycle. Nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline, clears the sums,
// minima, indexes, count and frozen flag, and loads the register defaults
// (gain 1.0, threshold 5.0). After an alarm the run stays frozen, every
// result reports frozen, until a request with start_req set.
module two_sided_cusum_detector
  import tscd_pkg::*;
#(
  parameter int MAX_RUN      = MAX_RUN_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  tscd_stream_if.sink      in_ch,
  tscd_stream_if.source    out_ch,
  tscd_stream_if.sink      cfg_ch
);

  localparam int IDX_CAP_I = (MAX_RUN - 1 > 65535) ? 65535 : MAX_RUN - 1;
  localparam logic [IDX_W-1:0] IDX_CAP = IDX_W'(IDX_CAP_I);

  // Configuration registers
  logic signed [MEAN_W-1:0] mean_r;
  logic [MAG_W-1:0]         mag_r;
  logic [GAIN_W-1:0]        gain_r;
  logic [THR_W-1:0]         thr_r;

  // Run state; min_thr holds minimum plus threshold for each side
  logic signed [SUM_W-1:0]  cum_up_r, cum_dn_r;
  logic signed [SUM_W-1:0]  min_up_r, min_dn_r;
  logic signed [SUM_W:0]    min_thr_up_r, min_thr_dn_r;
  logic [IDX_W-1:0]         min_idx_up_r, min_idx_dn_r;
  logic [IDX_W-1:0]         count_r;
  logic                     frozen_r;

  // Result register
  logic                     out_valid_r;
  out_res_t                 out_data_r;

  logic                     adv;
  stage_ctl_t               ctl_in;
  stage_ctl_t               ctl2;
  logic signed [SCORE_W-1:0] score_up, score_dn;

  logic                     frozen_eff;
  logic [IDX_W-1:0]         count_eff;
  logic [IDX_W-1:0]         count_nxt;
  logic                     first;
  logic                     update;
  logic signed [SUM_W:0]    thr_ext;
  logic signed [SUM_W:0]    sum_up, sum_dn;
  logic signed [SUM_W-1:0]  cum_up_nxt, cum_dn_nxt;
  logic                     new_min_up, new_min_dn;
  logic                     alarm_up, alarm_dn;
  out_res_t                 res;

  // Advance the whole pipeline when the result slot frees up
  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign cfg_ch.ready = 1'b1;
  assign ctl_in       = '{valid: in_ch.valid, start: in_ch.data.start_req};

  tscd_score #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_score (
    .clk        (clk),
    .rst_n      (rst_n),
    .en_i       (adv),
    .ctl_i      (ctl_in),
    .sample_i   (in_ch.data.sample),
    .mean_i     (mean_r),
    .mag_i      (mag_r),
    .gain_i     (gain_r),
    .ctl_o      (ctl2),
    .score_up_o (score_up),
    .score_dn_o (score_dn)
  );

  // Accumulate, track minima and test both sides
  always_comb begin
    frozen_eff = frozen_r && !ctl2.start;
    count_eff  = ctl2.start ? '0 : count_r;
    first      = (count_eff == '0);
    count_nxt  = (count_eff < IDX_CAP) ? count_eff + IDX_W'(1) : count_eff;
    thr_ext    = signed'({{(SUM_W+1-THR_W){1'b0}}, thr_r});

    sum_up = (first ? '0 : (SUM_W+1)'(cum_up_r)) + (SUM_W+1)'(score_up);
    sum_dn = (first ? '0 : (SUM_W+1)'(cum_dn_r)) + (SUM_W+1)'(score_dn);

    // Saturate on overflow of the 48-bit range
    if (sum_up[SUM_W] != sum_up[SUM_W-1]) begin
      cum_up_nxt = {sum_up[SUM_W], {(SUM_W-1){!sum_up[SUM_W]}}};
    end else begin
      cum_up_nxt = sum_up[SUM_W-1:0];
    end
    if (sum_dn[SUM_W] != sum_dn[SUM_W-1]) begin
      cum_dn_nxt = {sum_dn[SUM_W], {(SUM_W-1){!sum_dn[SUM_W]}}};
    end else begin
      cum_dn_nxt = sum_dn[SUM_W-1:0];
    end

    new_min_up = first || (cum_up_nxt < min_up_r);
    new_min_dn = first || (cum_dn_nxt < min_dn_r);
    // Sum minus minimum above threshold; a fresh minimum gives zero
    alarm_up   = !first && ((SUM_W+1)'(cum_up_nxt) > min_thr_up_r);
    alarm_dn   = !first && ((SUM_W+1)'(cum_dn_nxt) > min_thr_dn_r);

    update = adv && ctl2.valid && !frozen_eff;

    res = '0;
    if (frozen_eff) begin
      res.frozen = 1'b1;
    end else if (alarm_up) begin
      res.alarm        = 1'b1;
      res.side         = 1'b0;
      res.detect_index = count_eff;
      res.change_index = min_idx_up_r;
    end else if (alarm_dn) begin
      res.alarm        = 1'b1;
      res.side         = 1'b1;
      res.detect_index = count_eff;
      res.change_index = min_idx_dn_r;
    end
  end

  // Run state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r       <= '0;
      mag_r        <= '0;
      gain_r       <= GAIN_RESET;
      thr_r        <= THR_RESET;
      cum_up_r     <= '0;
      cum_dn_r     <= '0;
      min_up_r     <= '0;
      min_dn_r     <= '0;
      min_thr_up_r <= signed'({{(SUM_W+1-THR_W){1'b0}}, THR_RESET});
      min_thr_dn_r <= signed'({{(SUM_W+1-THR_W){1'b0}}, THR_RESET});
      min_idx_up_r <= '0;
      min_idx_dn_r <= '0;
      count_r      <= '0;
      frozen_r     <= 1'b0;
    end else if (update) begin
      count_r  <= count_nxt;
      cum_up_r <= cum_up_nxt;
      cum_dn_r <= cum_dn_nxt;
      frozen_r <= alarm_up || alarm_dn;
      if (new_min_up) begin
        min_up_r     <= cum_up_nxt;
        min_thr_up_r <= (SUM_W+1)'(cum_up_nxt) + thr_ext;
        min_idx_up_r <= count_eff;
      end
      if (new_min_dn) begin
        min_dn_r     <= cum_dn_nxt;
        min_thr_dn_r <= (SUM_W+1)'(cum_dn_nxt) + thr_ext;
        min_idx_dn_r <= count_eff;
      end
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.index)
        REG_MEAN_REF:   mean_r <= signed'(cfg_ch.data.wdata[MEAN_W-1:0]);
        REG_CHANGE_MAG: mag_r  <= cfg_ch.data.wdata[MAG_W-1:0];
        REG_GAIN:       gain_r <= cfg_ch.data.wdata[GAIN_W-1:0];
        REG_THRESHOLD: begin
          thr_r        <= cfg_ch.data.wdata[THR_W-1:0];
          min_thr_up_r <= (SUM_W+1)'(min_up_r) +
                          signed'({{(SUM_W+1-THR_W){1'b0}}, cfg_ch.data.wdata[THR_W-1:0]});
          min_thr_dn_r <= (SUM_W+1)'(min_dn_r) +
                          signed'({{(SUM_W+1-THR_W){1'b0}}, cfg_ch.data.wdata[THR_W-1:0]});
        end
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // The cached minimum-plus-threshold always matches its parts
  a_min_thr_up: assert property (@(posedge clk) disable iff (!rst_n)
    min_thr_up_r == (SUM_W+1)'(min_up_r) + thr_ext)
    else $error("upward minimum plus threshold out of step");

  a_min_thr_dn: assert property (@(posedge clk) disable iff (!rst_n)
    min_thr_dn_r == (SUM_W+1)'(min_dn_r) + thr_ext)
    else $error("downward minimum plus threshold out of step");

  // An alarm taken into the result register freezes the run
  a_alarm_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    update && (alarm_up || alarm_dn) |=> frozen_r && out_valid_r && out_data_r.alarm)
    else $error("alarm did not freeze the run");

  // The sample index never passes its cap
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= IDX_CAP)
    else $error("sample index beyond cap");

  // The change point never lies after the detection point, and an alarm is never frozen
  a_change_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.alarm |->
      out_data_r.change_index <= out_data_r.detect_index && !out_data_r.frozen)
    else $error("change index after detection index");

endmodule

[sim/tb.sv]
module tb
  import tscd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          HALF_PERIOD  = 4;
  localparam int          RESET_CYCLES = 5;
  localparam int          CYCLE_LIMIT  = 50_000;
  localparam int          LONG_RUN     = 20;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          SAMPLE_LO    = -32768;
  localparam int          SAMPLE_HI    = 32767;
  localparam bit          SIDE_UP      = 1'b0;
  localparam bit          SIDE_DOWN    = 1'b1;
  localparam longint      SUM_TOP      = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint      SUM_BOTTOM   = -SUM_TOP - 1;
  localparam longint      THR_TOP      = (longint'(1) <<< THR_W) - 1;
  localparam int unsigned INDEX_LIMIT  = (MAX_RUN_DEF - 1 > 65535) ? 65535 : MAX_RUN_DEF - 1;

  typedef enum int {SET_TYPICAL, SET_EXTREME, SET_RAW} setting_kind_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  tscd_stream_if #(.T(in_req_t))  in_if ();
  tscd_stream_if #(.T(out_res_t)) out_if ();
  tscd_stream_if #(.T(cfg_req_t)) cfg_if ();

  two_sided_cusum_detector i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Detector state as predicted
  longint      up_sum        = 0;
  longint      down_sum      = 0;
  longint      up_floor      = 0;
  longint      down_floor    = 0;
  int unsigned up_floor_at   = 0;
  int unsigned down_floor_at = 0;
  int unsigned run_index     = 0;
  bit          run_latched   = 1'b0;

  // Register values as predicted
  longint mean_val = 0;
  longint mag_val  = 0;
  longint gain_val = longint'(GAIN_RESET);
  longint thr_val  = longint'(THR_RESET);

  in_req_t     sample_queue[$];
  out_res_t    expected_results[$];
  int unsigned samples_queued = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;
  int unsigned holds_asked    = 0;
  int unsigned holds_done     = 0;
  int unsigned cycle_count    = 0;
  out_res_t    got_res;
  out_res_t    want_res;

  always #(HALF_PERIOD) clk = ~clk;

  // Score of one side: gain * (2*d - magnitude), halved towards minus infinity
  function automatic longint half_score(longint diff);
    longint prod;
    prod = gain_val * (2 * diff - mag_val);
    return prod >>> 1;
  endfunction

  function automatic longint clamp_sum(longint acc, longint delta);
    longint total;
    total = acc + delta;
    if (total > SUM_TOP) return SUM_TOP;
    if (total < SUM_BOTTOM) return SUM_BOTTOM;
    return total;
  endfunction

  // Advance the predicted detector by one request and return its result
  function automatic out_res_t detect_step(in_req_t req);
    out_res_t    res;
    longint      x;
    longint      up_gap;
    longint      down_gap;
    int unsigned idx;
    bit          first;
    res = '0;
    x   = longint'($signed(req.sample));
    if (req.start_req) begin
      up_sum        = 0;
      down_sum      = 0;
      up_floor      = 0;
      down_floor    = 0;
      up_floor_at   = 0;
      down_floor_at = 0;
      run_index     = 0;
      run_latched   = 1'b0;
    end
    if (run_latched) begin
      res.frozen = 1'b1;
      return res;
    end
    idx   = run_index;
    first = (idx == 0);
    if (run_index < INDEX_LIMIT) run_index++;
    up_sum   = clamp_sum(first ? 0 : up_sum, half_score(x - mean_val));
    down_sum = clamp_sum(first ? 0 : down_sum, half_score(mean_val - x));
    if (first || up_sum < up_floor) begin
      up_floor    = up_sum;
      up_floor_at = idx;
    end
    if (first || down_sum < down_floor) begin
      down_floor    = down_sum;
      down_floor_at = idx;
    end
    up_gap   = up_sum - up_floor;
    down_gap = down_sum - down_floor;
    // Upward side wins when both cross
    if (up_gap > thr_val) begin
      res.alarm        = 1'b1;
      res.side         = SIDE_UP;
      res.detect_index = IDX_W'(idx);
      res.change_index = IDX_W'(up_floor_at);
      run_latched      = 1'b1;
    end else if (down_gap > thr_val) begin
      res.alarm        = 1'b1;
      res.side         = SIDE_DOWN;
      res.detect_index = IDX_W'(idx);
      res.change_index = IDX_W'(down_floor_at);
      run_latched      = 1'b1;
    end
    return res;
  endfunction

  task automatic flag_mismatch(string what);
    mismatch_count++;
    $display("[%0t] result %0d: %s", $time, results_seen, what);
  endtask

  task automatic check_field(string name, longint got, longint want);
    if (got != want) flag_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  // Sender: offer queued requests, hold each until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) expected_results.push_back(detect_step(in_if.data));
      if (!in_if.valid || in_if.ready) begin
        if (sample_queue.size() != 0 && $urandom_range(99, 0) >= send_gap_pct) begin
          in_if.valid <= 1'b1;
          in_if.data  <= sample_queue.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each result with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got_res = out_if.data;
        results_seen++;
        if (expected_results.size() == 0) begin
          flag_mismatch("result with no request outstanding");
        end else begin
          want_res = expected_results.pop_front();
          check_field("alarm", got_res.alarm, want_res.alarm);
          check_field("side", got_res.side, want_res.side);
          check_field("detect_index", got_res.detect_index, want_res.detect_index);
          check_field("change_index", got_res.change_index, want_res.change_index);
          check_field("frozen", got_res.frozen, want_res.frozen);
        end
      end
      out_if.ready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off, started on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic queue_item(int value, bit start);
    in_req_t req;
    req.sample    = SAMPLE_W'(value);
    req.start_req = start;
    sample_queue.push_back(req);
    samples_queued++;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (results_seen < samples_queued);
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    send_gap_pct   <= send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // Write one register and track it in the prediction
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_if.valid       <= 1'b1;
    cfg_if.data.index  <= idx;
    cfg_if.data.wdata  <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_MEAN_REF:   mean_val = longint'($signed(value[MEAN_W-1:0]));
      REG_CHANGE_MAG: mag_val  = longint'(value[MAG_W-1:0]);
      REG_GAIN:       gain_val = longint'(value[GAIN_W-1:0]);
      REG_THRESHOLD:  thr_val  = longint'(value[THR_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic load_settings(longint mean, longint mag, longint gain, longint thr);
    write_reg(REG_MEAN_REF, CFG_DATA_W'(mean));
    write_reg(REG_CHANGE_MAG, CFG_DATA_W'(mag));
    write_reg(REG_GAIN, CFG_DATA_W'(gain));
    write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
  endtask

  task automatic pick_settings(setting_kind_t kind);
    longint mag;
    longint gain;
    longint step;
    case (kind)
      SET_EXTREME: begin
        load_settings($urandom_range(1, 0) ? SAMPLE_HI : SAMPLE_LO,
                      $urandom_range(1, 0) ? 65535 : 0,
                      $urandom_range(1, 0) ? 65535 : 0,
                      $urandom_range(1, 0) ? THR_TOP : 0);
      end
      SET_RAW: begin
        // Full-width data: the upper bits must be dropped
        write_reg(REG_MEAN_REF, CFG_DATA_W'({$urandom(), $urandom()}));
        write_reg(REG_CHANGE_MAG, CFG_DATA_W'({$urandom(), $urandom()}));
        write_reg(REG_GAIN, CFG_DATA_W'({$urandom(), $urandom()}));
        write_reg(REG_THRESHOLD, CFG_DATA_W'({$urandom(), $urandom()}));
      end
      default: begin
        // Threshold a few shifted samples deep, so runs alarm part way
        mag  = $urandom_range(3000, 1);
        gain = $urandom_range(1024, 16);
        step = gain * mag / 2;
        load_settings(longint'(int'($urandom_range(4000, 0)) - 2000), mag, gain,
                      longint'($urandom_range(8, 0)) * step + $urandom_range(1000, 0));
      end
    endcase
    if ($urandom_range(3, 0) == 0)
      write_reg(CFG_IDX_W'($urandom_range(255, REG_THRESHOLD + 1)),
                CFG_DATA_W'({$urandom(), $urandom()}));
  endtask

  // One run: noise around the mean, then a step up or down at a random point
  task automatic queue_run(int len);
    int i;
    int shift_at;
    int offset;
    int spread;
    int value;
    bit down_shift;
    shift_at   = $urandom_range(len, 0);
    down_shift = $urandom_range(1, 0);
    spread     = int'(mag_val / 4) + 2;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(99, 0) < 8) begin
        queue_item(int'($urandom_range(65535, 0)) + SAMPLE_LO, $urandom_range(1, 0));
      end else begin
        offset = (i >= shift_at) ? (down_shift ? -int'(mag_val) : int'(mag_val)) : 0;
        value  = int'(mean_val) + offset + int'($urandom_range(2 * spread, 0)) - spread;
        if (value < SAMPLE_LO) value = SAMPLE_LO;
        if (value > SAMPLE_HI) value = SAMPLE_HI;
        queue_item(value, (i == 0) && ($urandom_range(99, 0) < 90));
      end
    end
  endtask

  task automatic run_block(int n_items);
    int target;
    int len;
    target = samples_queued + n_items;
    while (samples_queued < target) begin
      len = $urandom_range(40, 3);
      if (len > target - samples_queued) len = target - samples_queued;
      queue_run(len);
    end
    wait_drained();
  endtask

  initial begin
    int i;
    int phase;
    int blk;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Defaults, no start after reset: alarm up, then frozen
    queue_item(0, 1'b0);
    queue_item(3, 1'b0);
    queue_item(3, 1'b0);
    queue_item(5, 1'b0);
    // Start requests and full-scale steps in both directions
    queue_item(SAMPLE_HI, 1'b1);
    queue_item(SAMPLE_LO, 1'b0);
    queue_item(SAMPLE_LO, 1'b1);
    queue_item(SAMPLE_HI, 1'b0);
    queue_item(-1, 1'b0);
    queue_item(0, 1'b1);
    wait_drained();

    // Both sides crossing at once: climb under a high threshold, then drop it
    write_reg(REG_THRESHOLD, '1);
    queue_item(0, 1'b1);
    queue_item(10, 1'b0);
    wait_drained();
    write_reg(REG_THRESHOLD, '0);
    queue_item(-1, 1'b0);
    queue_item(0, 1'b0);
    wait_drained();

    // Register extremes with junk in the upper bits, and an unknown index
    write_reg(REG_MEAN_REF, 48'hABCD_1234_8000);
    write_reg(REG_CHANGE_MAG, 48'h5555_0000_FFFF);
    write_reg(REG_GAIN, '1);
    write_reg(REG_THRESHOLD, 48'h8000_0000_0000);
    write_reg(CFG_IDX_W'(REG_THRESHOLD + 1), '1);
    queue_item(SAMPLE_HI, 1'b1);
    queue_item(SAMPLE_LO, 1'b0);
    queue_item(SAMPLE_HI, 1'b0);
    queue_item(0, 1'b0);
    queue_item(SAMPLE_LO, 1'b1);
    queue_item(SAMPLE_LO, 1'b0);
    wait_drained();

    // Full-scale run under the top threshold, then drop it to force an alarm
    load_settings(SAMPLE_HI, 65535, 65535, THR_TOP);
    queue_item(SAMPLE_LO, 1'b1);
    for (i = 1; i < LONG_RUN; i++) queue_item(SAMPLE_LO + int'($urandom_range(255, 0)), 1'b0);
    wait_drained();
    write_reg(REG_THRESHOLD, '0);
    queue_item(SAMPLE_LO, 1'b0);
    queue_item(SAMPLE_LO, 1'b0);
    wait_drained();

    // Hold the receiver off while requests keep coming
    pick_settings(SET_TYPICAL);
    holds_asked <= holds_asked + 1;
    run_block(120);

    // Random runs under each idling pattern
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       set_idling(0, 0);
        1:       set_idling(50, 0);
        2:       set_idling(0, 50);
        default: set_idling(6, 6);
      endcase
      for (blk = 0; blk < 4; blk++) begin
        pick_settings(blk == 0 ? SET_EXTREME : (blk == 1 ? SET_RAW : SET_TYPICAL));
        run_block(50);
      end
    end

    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) flag_mismatch("requests left without a result");
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
